/* design/wsfhp_pkg.sv */
package wsfhp_pkg;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_PAY  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RSV_OP   = 3'd1,
    ERR_FRAG_CTL = 3'd2,
    ERR_CTL_LEN  = 3'd3,
    ERR_LEN_MSB  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    OPC_DATA,
    OPC_CTL,
    OPC_RSV
  } opc_cls_t;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    opc_cls_t   opc_cls;
    len_cls_t   len_cls;
  } q_item_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [7:0]  data_out;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [31:0] key_value;
    logic [62:0] frame_length;
    logic        frame_end;
    logic [2:0]  error_code;
  } out_item_t;

endpackage

/* design/wsfhp_front.sv */
module wsfhp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsfhp_pkg::in_item_t in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output wsfhp_pkg::q_item_t  q_item
);
  import wsfhp_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  q_item_t            cls_item;
  logic               push;
  logic               pop;

  // Every byte is classified both as a possible first header byte and as a
  // possible second header byte; the parser picks whichever applies.
  always_comb begin
    cls_item.data_byte = in_data.data_byte;
    cls_item.restart   = in_data.restart;
    case (in_data.data_byte[3:0]) inside
      4'h0, 4'h1, 4'h2: cls_item.opc_cls = OPC_DATA;
      [4'h8:4'hA]:      cls_item.opc_cls = OPC_CTL;
      default:          cls_item.opc_cls = OPC_RSV;
    endcase
    if (in_data.data_byte[6:0] == LEN_CODE_16) begin
      cls_item.len_cls = LEN_EXT16;
    end else if (in_data.data_byte[6:0] == LEN_CODE_64) begin
      cls_item.len_cls = LEN_EXT64;
    end else begin
      cls_item.len_cls = LEN_SHORT;
    end
  end

  assign in_ready = (count_r != FULL_CNT);
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_ONE;
      end else if (pop && !push) begin
        count_r <= count_r - CNT_ONE;
      end
    end
  end

endmodule

/* design/wsfhp_back.sv */
module wsfhp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  wsfhp_pkg::q_item_t   q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsfhp_pkg::out_item_t out_data
);
  import wsfhp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_LEN16,
    PH_LEN64,
    PH_KEY,
    PH_DATA,
    PH_ERR
  } phase_t;

  localparam logic [3:0] LEN16_BYTES = 4'd2;
  localparam logic [3:0] LEN64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  phase_t      phase_r, phase_nxt, ph;
  logic [3:0]  count_r, count_nxt, cnt_inc;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  opc_cls_t    opc_cls_r, opc_cls_nxt;
  logic        mask_r, mask_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] length_r, length_nxt, len_shift;
  logic [62:0] left_r, left_nxt;
  err_t        sticky_r, sticky_nxt;
  kind_t       kind;
  logic        fend;
  logic        do_after;
  logic        do_finish;
  logic [7:0]  b;
  logic        pop;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    b           = q_item.data_byte;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    opc_cls_nxt = opc_cls_r;
    mask_nxt    = mask_r;
    key_nxt     = key_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    count_nxt   = count_r;
    kind        = KIND_HDR;
    fend        = 1'b0;
    do_after    = 1'b0;
    do_finish   = 1'b0;
    cnt_inc     = count_r + 4'd1;
    len_shift   = {length_r[55:0], b};
    if (q_item.restart) begin
      ph         = PH_HDR0;
      sticky_nxt = ERR_NONE;
    end else begin
      ph         = phase_r;
      sticky_nxt = sticky_r;
    end
    phase_nxt = ph;

    case (ph)
      PH_HDR0: begin
        fin_nxt     = b[7];
        opcode_nxt  = b[3:0];
        opc_cls_nxt = q_item.opc_cls;
        mask_nxt    = 1'b0;
        key_nxt     = '0;
        length_nxt  = '0;
        left_nxt    = '0;
        count_nxt   = '0;
        phase_nxt   = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = b[7];
        if (opc_cls_r == OPC_RSV) begin
          sticky_nxt = ERR_RSV_OP;
          phase_nxt  = PH_ERR;
        end else if (opc_cls_r == OPC_CTL && !fin_r) begin
          sticky_nxt = ERR_FRAG_CTL;
          phase_nxt  = PH_ERR;
        end else if (opc_cls_r == OPC_CTL && q_item.len_cls != LEN_SHORT) begin
          sticky_nxt = ERR_CTL_LEN;
          phase_nxt  = PH_ERR;
        end else begin
          count_nxt = '0;
          case (q_item.len_cls)
            LEN_SHORT: begin
              length_nxt = {57'd0, b[6:0]};
              do_after   = 1'b1;
            end
            LEN_EXT16: phase_nxt = PH_LEN16;
            default:   phase_nxt = PH_LEN64;
          endcase
        end
      end
      PH_LEN16: begin
        length_nxt = {48'd0, length_r[7:0], b};
        count_nxt  = cnt_inc;
        do_after   = (cnt_inc >= LEN16_BYTES);
      end
      PH_LEN64: begin
        length_nxt = len_shift;
        count_nxt  = cnt_inc;
        if (cnt_inc >= LEN64_BYTES) begin
          if (len_shift[63]) begin
            sticky_nxt = ERR_LEN_MSB;
            phase_nxt  = PH_ERR;
          end else begin
            do_after = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt   = {key_r[23:0], b};
        count_nxt = cnt_inc;
        do_finish = (cnt_inc >= KEY_BYTES);
      end
      PH_DATA: begin
        kind = KIND_PAY;
        if (left_r != '0) begin
          left_nxt = left_r - 63'd1;
        end
        if (left_r[62:1] == '0) begin
          fend      = 1'b1;
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    if (do_after) begin
      count_nxt = '0;
      if (mask_nxt) begin
        phase_nxt = PH_KEY;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      left_nxt  = length_nxt[62:0];
      count_nxt = '0;
      kind      = KIND_DONE;
      if (length_nxt[62:0] == '0) begin
        fend      = 1'b1;
        phase_nxt = PH_HDR0;
      end else begin
        phase_nxt = PH_DATA;
      end
    end

    if (phase_nxt == PH_ERR) begin
      kind = KIND_ERR;
    end

    out_data_nxt.byte_kind    = kind;
    out_data_nxt.data_out     = b;
    out_data_nxt.fin_flag     = fin_nxt;
    out_data_nxt.frame_opcode = opcode_nxt;
    out_data_nxt.mask_present = mask_nxt;
    out_data_nxt.key_value    = key_nxt;
    out_data_nxt.frame_length = length_nxt[62:0];
    out_data_nxt.frame_end    = (kind == KIND_ERR) ? 1'b0 : fend;
    out_data_nxt.error_code   = sticky_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      sticky_r    <= ERR_NONE;
      count_r     <= '0;
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      opc_cls_r   <= OPC_DATA;
      mask_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        sticky_r    <= sticky_nxt;
        count_r     <= count_nxt;
        fin_r       <= fin_nxt;
        opcode_r    <= opcode_nxt;
        opc_cls_r   <= opc_cls_nxt;
        mask_r      <= mask_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_r      <= key_nxt;
      length_r   <= length_nxt;
      left_r     <= left_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/ws_frame_header_parser.sv */
// Each input transfer is registered first in the two-entry input queue and then in the
// parser's output register; the parser stalls while that register holds an untaken result.
// Throughput: one byte per cycle while out_ready is held high, set by the header state machine.
// Reset: rst_n is synchronous and active low; it empties the queue, drops the result
// and returns the parser to the first header byte with no error.
module ws_frame_header_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wsfhp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsfhp_pkg::out_item_t out_data
);
  import wsfhp_pkg::*;

  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  wsfhp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  wsfhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_err_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.byte_kind == KIND_ERR) == (out_data.error_code != ERR_NONE)))
    else $error("Error kind and sticky error code disagree.");

  a_key_unmasked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mask_present |-> out_data.key_value == '0)
    else $error("Masking key is nonzero on an unmasked frame.");

  a_empty_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_kind == KIND_DONE && out_data.frame_end
      |-> out_data.frame_length == '0)
    else $error("Frame ended at header complete with a nonzero length.");

  a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("Input queue refuses a transfer while empty.");

endmodule

/* verif/tb.sv */
module tb;
  import wsfhp_pkg::*;

  localparam int unsigned NUM_DIRECTED = 28;
  localparam int unsigned RANDOM_BYTES = 750;
  localparam int unsigned PAUSE_AT = 400;
  localparam int unsigned SQUEEZE_AFTER = 150;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT = 2000;

  localparam logic [3:0] OPC_LAST_DATA = 4'h2;
  localparam logic [3:0] OPC_FIRST_CTL = 4'h8;
  localparam logic [3:0] OPC_LAST_CTL = 4'hA;
  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef enum logic [2:0] {
    ST_FIRST, ST_SECOND, ST_LEN16, ST_LEN64, ST_KEY, ST_PAYLOAD, ST_FAILED
  } stage_t;

  typedef enum int {
    FLAW_NONE, FLAW_RSV_OPCODE, FLAW_FRAG_CTL, FLAW_CTL_LONG, FLAW_LEN_MSB, FLAW_CUT, FLAW_JUNK
  } flaw_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       typed;
    kind_t      kind;
    logic       fin;
    logic [3:0] opcode;
    logic       mask;
    logic       last;
    err_t       err;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic      stim_typed;
  out_item_t stim_want;

  stage_t      stage = ST_FIRST;
  logic [3:0]  ext_count = '0;
  logic        cur_fin = 1'b0;
  logic [3:0]  cur_opcode = '0;
  logic        cur_mask = 1'b0;
  logic [31:0] cur_key = '0;
  logic [63:0] cur_length = '0;
  logic [62:0] payload_left = '0;
  err_t        latched_error = ERR_NONE;

  out_item_t   pending_results [$];
  in_item_t    stream [$];
  stim_row_t   directed_rows [0:NUM_DIRECTED-1];
  logic        need_restart = 1'b0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned failures = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned headers_done = 0;
  int unsigned payload_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned frames_built = 0;
  int unsigned idle_cycles = 0;

  ws_frame_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function out_item_t parse_byte(input in_item_t item);
    logic [7:0] b;
    logic [6:0] code7;
    logic       is_ctl;
    logic       length_known;
    logic       header_done;
    logic       last;
    kind_t      kind;
    out_item_t  r;
    b = item.data_byte;
    kind = KIND_HDR;
    last = 1'b0;
    length_known = 1'b0;
    header_done = 1'b0;
    if (item.restart) begin
      stage = ST_FIRST;
      ext_count = '0;
      cur_fin = 1'b0;
      cur_opcode = '0;
      cur_mask = 1'b0;
      cur_key = '0;
      cur_length = '0;
      payload_left = '0;
      latched_error = ERR_NONE;
    end
    case (stage)
      ST_FIRST: begin
        cur_fin = b[7];
        cur_opcode = b[3:0];
        cur_mask = 1'b0;
        cur_key = '0;
        cur_length = '0;
        payload_left = '0;
        ext_count = '0;
        stage = ST_SECOND;
      end
      ST_SECOND: begin
        code7 = b[6:0];
        is_ctl = (cur_opcode >= OPC_FIRST_CTL);
        cur_mask = b[7];
        if ((cur_opcode > OPC_LAST_DATA && cur_opcode < OPC_FIRST_CTL) ||
            cur_opcode > OPC_LAST_CTL) begin
          latched_error = ERR_RSV_OP;
        end else if (is_ctl && !cur_fin) begin
          latched_error = ERR_FRAG_CTL;
        end else if (is_ctl && code7 > LEN_MAX_SHORT) begin
          latched_error = ERR_CTL_LEN;
        end
        if (latched_error != ERR_NONE) begin
          stage = ST_FAILED;
        end else begin
          ext_count = '0;
          if (code7 <= LEN_MAX_SHORT) begin
            cur_length = {57'd0, code7};
            length_known = 1'b1;
          end else if (code7 == LEN_CODE_16) begin
            stage = ST_LEN16;
          end else begin
            stage = ST_LEN64;
          end
        end
      end
      ST_LEN16: begin
        cur_length = {48'd0, cur_length[7:0], b};
        ext_count = ext_count + 4'd1;
        if (ext_count >= 4'd2) begin
          length_known = 1'b1;
        end
      end
      ST_LEN64: begin
        cur_length = {cur_length[55:0], b};
        ext_count = ext_count + 4'd1;
        if (ext_count >= 4'd8) begin
          if (cur_length[63]) begin
            latched_error = ERR_LEN_MSB;
            stage = ST_FAILED;
          end else begin
            length_known = 1'b1;
          end
        end
      end
      ST_KEY: begin
        cur_key = {cur_key[23:0], b};
        ext_count = ext_count + 4'd1;
        if (ext_count >= 4'd4) begin
          header_done = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        kind = KIND_PAY;
        if (payload_left != '0) begin
          payload_left = payload_left - 63'd1;
        end
        if (payload_left == '0) begin
          last = 1'b1;
          stage = ST_FIRST;
        end
      end
      default: begin
        stage = ST_FAILED;
      end
    endcase
    if (length_known) begin
      ext_count = '0;
      if (cur_mask) begin
        stage = ST_KEY;
      end else begin
        header_done = 1'b1;
      end
    end
    if (header_done) begin
      payload_left = cur_length[62:0];
      if (payload_left == '0) begin
        last = 1'b1;
        stage = ST_FIRST;
      end else begin
        stage = ST_PAYLOAD;
      end
      ext_count = '0;
      kind = KIND_DONE;
    end
    if (stage == ST_FAILED) begin
      kind = KIND_ERR;
    end
    r.byte_kind = kind;
    r.data_out = b;
    r.fin_flag = cur_fin;
    r.frame_opcode = cur_opcode;
    r.mask_present = cur_mask;
    r.key_value = cur_key;
    r.frame_length = cur_length[62:0];
    r.frame_end = (kind == KIND_ERR) ? 1'b0 : last;
    r.error_code = latched_error;
    return r;
  endfunction

  function void compare_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failures++;
    end
  endfunction

  function automatic int unsigned idle_gap(input bit steady);
    if (steady || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = parse_byte(in_data);
        pending_results = {pending_results, stim_typed ? stim_want : predicted};
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with data_out 0x%0h arrived with nothing expected", out_data.data_out);
          failures++;
        end else begin
          want = pending_results.pop_front();
          compare_field("byte_kind", 64'(want.byte_kind), 64'(out_data.byte_kind));
          compare_field("data_out", 64'(want.data_out), 64'(out_data.data_out));
          compare_field("fin_flag", 64'(want.fin_flag), 64'(out_data.fin_flag));
          compare_field("frame_opcode", 64'(want.frame_opcode), 64'(out_data.frame_opcode));
          compare_field("mask_present", 64'(want.mask_present), 64'(out_data.mask_present));
          compare_field("key_value", 64'(want.key_value), 64'(out_data.key_value));
          compare_field("frame_length", 64'(want.frame_length), 64'(out_data.frame_length));
          compare_field("frame_end", 64'(want.frame_end), 64'(out_data.frame_end));
          compare_field("error_code", 64'(want.error_code), 64'(out_data.error_code));
          results_seen++;
          if (out_data.byte_kind == KIND_DONE) begin
            headers_done++;
          end else if (out_data.byte_kind == KIND_PAY) begin
            payload_seen++;
          end else if (out_data.byte_kind == KIND_ERR) begin
            errors_seen++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ws_frame_header_parser regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!rx_steady && $urandom_range(0, 15) == 0) begin
        rx_steady = 1'b1;
      end else if (rx_steady && $urandom_range(0, 7) == 0) begin
        rx_steady = 1'b0;
      end
      if (bytes_taken >= SQUEEZE_AFTER && bytes_taken < SQUEEZE_AFTER + 100 &&
          !rx_steady && hold != SQUEEZE_CYCLES) begin
        out_ready <= 1'b0;
        hold = SQUEEZE_CYCLES;
      end else begin
        hold = idle_gap(rx_steady);
        if (hold == 0) begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 6);
        end else begin
          out_ready <= 1'b0;
        end
      end
      repeat (hold) @(negedge clk);
    end
  end

  task send_item(input in_item_t item, input logic typed, input out_item_t want);
    int unsigned gap;
    @(negedge clk);
    if ($urandom_range(0, 31) == 0) begin
      tx_steady = !tx_steady;
    end
    gap = idle_gap(tx_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    stim_typed <= typed;
    stim_want <= want;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task compose_frame();
    flaw_t       flaw;
    len_cls_t    form;
    logic        fin;
    logic        masked;
    logic        is_ctl;
    logic [3:0]  opcode;
    logic [2:0]  rsv;
    logic [63:0] length;
    logic [31:0] key;
    logic [6:0]  code7;
    logic [7:0]  bytes [$];
    in_item_t    item;
    int unsigned pick;
    int unsigned body;
    int unsigned cut;
    bytes.delete();
    flaw = ($urandom_range(0, 9) < 8) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
    if (flaw == FLAW_JUNK) begin
      repeat ($urandom_range(1, 6)) bytes = {bytes, 8'($urandom)};
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        length = 64'($urandom_range(0, 8));
      end else if (pick < 94) begin
        length = 64'($urandom_range(9, 40));
      end else if (pick < 98) begin
        length = 64'($urandom_range(41, 125));
      end else begin
        length = 64'($urandom_range(126, 300));
      end
      is_ctl = ($urandom_range(0, 2) == 0);
      if (is_ctl) begin
        opcode = 4'(OPC_FIRST_CTL + $urandom_range(0, 2));
        fin = 1'b1;
        if (length > LEN_MAX_SHORT) begin
          length = length % 126;
        end
        form = LEN_SHORT;
      end else begin
        opcode = 4'($urandom_range(0, OPC_LAST_DATA));
        fin = 1'($urandom_range(0, 1));
        if (length > LEN_MAX_SHORT || $urandom_range(0, 3) == 0) begin
          form = ($urandom_range(0, 2) == 0) ? LEN_EXT64 : LEN_EXT16;
        end else begin
          form = LEN_SHORT;
        end
      end
      masked = 1'($urandom_range(0, 1));
      key = $urandom;
      rsv = 3'($urandom_range(0, 7));
      case (flaw)
        FLAW_RSV_OPCODE: begin
          pick = $urandom_range(0, 9);
          opcode = (pick < 5) ? 4'(3 + pick) : 4'(6 + pick);
        end
        FLAW_FRAG_CTL: begin
          opcode = 4'(OPC_FIRST_CTL + $urandom_range(0, 2));
          fin = 1'b0;
        end
        FLAW_CTL_LONG: begin
          opcode = 4'(OPC_FIRST_CTL + $urandom_range(0, 2));
          fin = 1'b1;
          form = ($urandom_range(0, 1) == 0) ? LEN_EXT16 : LEN_EXT64;
        end
        FLAW_LEN_MSB: begin
          opcode = 4'($urandom_range(0, OPC_LAST_DATA));
          form = LEN_EXT64;
          length = {1'b1, 31'($urandom), 32'($urandom)};
        end
        FLAW_CUT: begin
          if ($urandom_range(0, 1) == 0) begin
            opcode = 4'($urandom_range(0, OPC_LAST_DATA));
            form = LEN_EXT64;
            length = {1'b0, 31'($urandom), 32'($urandom)};
          end
        end
        default: begin
        end
      endcase
      if (form == LEN_SHORT) begin
        code7 = length[6:0];
      end else begin
        code7 = (form == LEN_EXT16) ? LEN_CODE_16 : LEN_CODE_64;
      end
      bytes = {bytes, {fin, rsv, opcode}};
      bytes = {bytes, {masked, code7}};
      if (form == LEN_EXT16) begin
        bytes = {bytes, length[15:8]};
        bytes = {bytes, length[7:0]};
      end else if (form == LEN_EXT64) begin
        for (int i = 7; i >= 0; i--) bytes = {bytes, length[8*i +: 8]};
      end
      if (masked) begin
        for (int i = 3; i >= 0; i--) bytes = {bytes, key[8*i +: 8]};
      end
      if (flaw == FLAW_NONE) begin
        body = int'(length);
      end else if (flaw == FLAW_CUT) begin
        body = (length > 30) ? 30 : int'(length);
      end else begin
        body = $urandom_range(0, 3);
      end
      repeat (body) bytes = {bytes, 8'($urandom)};
      if (flaw == FLAW_CUT) begin
        cut = $urandom_range(1, bytes.size() - 1);
        while (bytes.size() > cut) void'(bytes.pop_back());
      end
    end
    foreach (bytes[i]) begin
      item.data_byte = bytes[i];
      item.restart = (i == 0) && (need_restart || $urandom_range(0, 19) == 0);
      stream = {stream, item};
    end
    need_restart = (flaw != FLAW_NONE);
    frames_built++;
  endtask

  initial begin
    stim_row_t   row;
    in_item_t    item;
    out_item_t   want;
    int unsigned offered;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_typed = 1'b0;
    stim_want = '0;
    directed_rows = '{
      {8'h89, 1'b1, 1'b1, KIND_HDR, 1'b1, 4'h9, 1'b0, 1'b0, ERR_NONE},
      {8'h80, 1'b0, 13'h0},
      {8'hFF, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'hA5, 1'b0, 13'h0},
      {8'h5A, 1'b0, 13'h0},
      {8'h88, 1'b0, 13'h0},
      {8'h7E, 1'b0, 1'b1, KIND_ERR, 1'b1, 4'h8, 1'b0, 1'b0, ERR_CTL_LEN},
      {8'hAB, 1'b0, 1'b1, KIND_ERR, 1'b1, 4'h8, 1'b0, 1'b0, ERR_CTL_LEN},
      {8'h0A, 1'b1, 1'b1, KIND_HDR, 1'b0, 4'hA, 1'b0, 1'b0, ERR_NONE},
      {8'h01, 1'b0, 1'b1, KIND_ERR, 1'b0, 4'hA, 1'b0, 1'b0, ERR_FRAG_CTL},
      {8'h8F, 1'b1, 1'b1, KIND_HDR, 1'b1, 4'hF, 1'b0, 1'b0, ERR_NONE},
      {8'hFF, 1'b0, 1'b1, KIND_ERR, 1'b1, 4'hF, 1'b1, 1'b0, ERR_RSV_OP},
      {8'h82, 1'b1, 1'b1, KIND_HDR, 1'b1, 4'h2, 1'b0, 1'b0, ERR_NONE},
      {8'h7F, 1'b0, 13'h0},
      {8'h80, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h00, 1'b0, 1'b1, KIND_ERR, 1'b1, 4'h2, 1'b0, 1'b0, ERR_LEN_MSB},
      {8'h71, 1'b1, 1'b1, KIND_HDR, 1'b0, 4'h1, 1'b0, 1'b0, ERR_NONE},
      {8'h7E, 1'b0, 13'h0},
      {8'h00, 1'b0, 13'h0},
      {8'h01, 1'b0, 13'h0},
      {8'hFF, 1'b0, 13'h0}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      item.data_byte = row.data_byte;
      item.restart = row.restart;
      want = '0;
      want.byte_kind = row.kind;
      want.data_out = row.data_byte;
      want.fin_flag = row.fin;
      want.frame_opcode = row.opcode;
      want.mask_present = row.mask;
      want.frame_end = row.last;
      want.error_code = row.err;
      send_item(item, row.typed, want);
    end

    offered = 0;
    while (offered < RANDOM_BYTES) begin
      if (stream.size() == 0) begin
        compose_frame();
      end
      if (offered == PAUSE_AT) begin
        wait_for_drain();
      end
      send_item(stream.pop_front(), 1'b0, '0);
      offered++;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d results for %0d bytes over %0d random frames plus the directed table.",
             results_seen, bytes_taken, frames_built);
    $display("Saw %0d completed headers, %0d payload bytes and %0d error bytes.",
             headers_done, payload_seen, errors_seen);
    if (failures == 0) begin
      $display("ws_frame_header_parser regression: pass");
    end else begin
      $display("ws_frame_header_parser regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/wsfhp_pkg.sv
design/wsfhp_front.sv
design/wsfhp_back.sv
design/ws_frame_header_parser.sv
verif/tb.sv
